// ----- rtl/q2e_pkg.sv -----
// shared types, constants and functions for the quaternion to euler block
package q2e_pkg;

  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int TABLE_LEN          = 24;
  localparam int QW                 = 16;
  localparam int PW                 = 36;   // product sum width
  localparam int CW                 = 44;   // cordic datapath width
  localparam int AW                 = 28;   // angle accumulator width, deg q16
  localparam int SQW                = 62;   // sqrt radicand width
  localparam int RTW                = 31;   // sqrt root width
  localparam logic signed [15:0] DECL_RESET = 16'sd1380;
  localparam logic signed [AW-1:0] DEG180 = AW'(180 * 65536);

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [AW-1:0] ang_t;

  typedef struct packed {
    logic  zero;
    cval_t x;
    cval_t y;
    ang_t  acc;
  } cvec_t;

  function automatic ang_t atan_lut(input int i);
    case (i)
      0: atan_lut = AW'(2949120);  1: atan_lut = AW'(1740967);
      2: atan_lut = AW'(919879);   3: atan_lut = AW'(466945);
      4: atan_lut = AW'(234379);   5: atan_lut = AW'(117304);
      6: atan_lut = AW'(58666);    7: atan_lut = AW'(29335);
      8: atan_lut = AW'(14668);    9: atan_lut = AW'(7334);
      10: atan_lut = AW'(3667);    11: atan_lut = AW'(1833);
      12: atan_lut = AW'(917);     13: atan_lut = AW'(458);
      14: atan_lut = AW'(229);     15: atan_lut = AW'(115);
      16: atan_lut = AW'(57);      17: atan_lut = AW'(29);
      18: atan_lut = AW'(14);      19: atan_lut = AW'(7);
      20: atan_lut = AW'(4);       21: atan_lut = AW'(2);
      22: atan_lut = AW'(1);
      default: atan_lut = '0;
    endcase
  endfunction

  // quadrant fix and normalize up to 2^40
  function automatic cvec_t cordic_prep(input cval_t y_in, input cval_t x_in);
    cvec_t v;
    logic [CW-1:0] ax, ay, mo;
    int sh;
    v.zero = (x_in == '0) && (y_in == '0);
    v.acc  = '0;
    v.x    = x_in;
    v.y    = y_in;
    if (x_in < 0) begin
      v.acc = (y_in >= 0) ? DEG180 : -DEG180;
      v.x   = -x_in;
      v.y   = -y_in;
    end
    ax = v.x[CW-1] ? -v.x : v.x;
    ay = v.y[CW-1] ? -v.y : v.y;
    mo = ax | ay;
    sh = 0;
    for (int k = 0; k <= 40; k++) begin
      if (mo[k]) sh = 40 - k;
    end
    if (v.zero) sh = 0;
    v.x = v.x <<< sh;
    v.y = v.y <<< sh;
    return v;
  endfunction

  // round half away from zero to hundredths
  function automatic logic signed [17:0] to_hund(input ang_t a);
    logic [AW-1:0] m;
    logic [AW+7:0] p;
    logic [17:0] r;
    m = a[AW-1] ? AW'(-a) : a;
    p = (AW+8)'(m) * (AW+8)'(100) + (AW+8)'(32768);
    r = p[33:16];
    return a[AW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [17:0] sat(input logic signed [17:0] v,
                                             input logic signed [17:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

endpackage

// ----- rtl/q2e_cordic_stage.sv -----
// one vectoring cordic micro-rotation, registered
module q2e_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  q2e_pkg::cvec_t  vec_in,
  output logic            vld_out,
  output q2e_pkg::cvec_t  vec_out
);
  q2e_pkg::cvec_t vec_nxt;
  q2e_pkg::cvec_t vec_r;
  logic           vld_r;

  always_comb begin
    vec_nxt = vec_in;
    if (vec_in.y >= 0) begin
      vec_nxt.x   = vec_in.x + (vec_in.y >>> STEP);
      vec_nxt.y   = vec_in.y - (vec_in.x >>> STEP);
      vec_nxt.acc = vec_in.acc + q2e_pkg::atan_lut(STEP);
    end else begin
      vec_nxt.x   = vec_in.x - (vec_in.y >>> STEP);
      vec_nxt.y   = vec_in.y + (vec_in.x >>> STEP);
      vec_nxt.acc = vec_in.acc - q2e_pkg::atan_lut(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vld_out = vld_r;
  assign vec_out = vec_r;
endmodule

// ----- rtl/q2e_isqrt.sv -----
// pipelined restoring square root, one root bit per stage
module q2e_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_in,
  input  logic [q2e_pkg::SQW-1:0]       rad_in,
  input  logic signed [q2e_pkg::CW-1:0] s_in,
  input  logic                          clamp_in,
  output logic                          vld_out,
  output logic [q2e_pkg::RTW-1:0]       root_out,
  output logic signed [q2e_pkg::CW-1:0] s_out,
  output logic                          clamp_out
);
  localparam int N = q2e_pkg::RTW;

  logic [q2e_pkg::SQW-1:0]       rem_r  [N+1];
  logic [N-1:0]                  root_r [N+1];
  logic signed [q2e_pkg::CW-1:0] s_r    [N+1];
  logic                          cl_r   [N+1];
  logic                          vld_r  [N+1];

  always_comb begin
    rem_r[0]  = rad_in;
    root_r[0] = '0;
    s_r[0]    = s_in;
    cl_r[0]   = clamp_in;
    vld_r[0]  = vld_in;
  end

  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam int B = N - 1 - k;
    logic [q2e_pkg::SQW:0] trial;
    logic [q2e_pkg::SQW:0] rem_nxt;
    logic [N-1:0]          root_nxt;
    always_comb begin
      trial = ({1'b0, (q2e_pkg::SQW)'(root_r[k])} << (B + 1))
              + ((q2e_pkg::SQW + 1)'(1) << (2 * B));
      if ({1'b0, rem_r[k]} >= trial) begin
        rem_nxt  = {1'b0, rem_r[k]} - trial;
        root_nxt = root_r[k] | (N'(1) << B);
      end else begin
        rem_nxt  = {1'b0, rem_r[k]};
        root_nxt = root_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        rem_r[k+1]  <= rem_nxt[q2e_pkg::SQW-1:0];
        root_r[k+1] <= root_nxt;
        s_r[k+1]    <= s_r[k];
        cl_r[k+1]   <= cl_r[k];
      end
    end
  end

  assign vld_out   = vld_r[N];
  assign root_out  = root_r[N];
  assign s_out     = s_r[N];
  assign clamp_out = cl_r[N];
endmodule

// ----- rtl/quaternion_to_euler_angles_top.sv -----
// quaternion to yaw, pitch, roll converter, top level
// usage: present one quaternion (w, x, y, z, signed fixed point) on the in_ channel
// with in_valid; it is taken when in_ready is also high. every transaction yields
// exactly one result on the out_ channel (yaw, pitch, roll in hundredths of a
// degree, plus a flag telling that the pitch sine was saturated).
// throughput: one quaternion per cycle, sustained while the output is not stalled.
// datapath: products, matrix terms and sine clamp, sine to q30, square, the
// one-bit-per-stage square root for the pitch cosine, cordic prep, a vectoring
// cordic of min(CORDIC_STEPS, TABLE_LEN) stages per angle lane, then the output.
// cfg_we writes the declination subtracted from yaw; write it while idle.
// reset (synchronous, rst_n low) empties the pipeline and sets the declination
// to 13.80 degrees.
// stall: the whole pipeline holds while the output register is full and
// out_ready is low; in_ready then drops. nothing is lost or repeated. bubbles
// travel with the pipeline and are not squeezed out.
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STEPS   = q2e_pkg::CORDIC_STEPS_DEF,
  parameter int QUAT_FRAC_BITS = q2e_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_yaw_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_roll_angle,
  output logic               out_pitch_clamped,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata
);
  localparam int CW   = q2e_pkg::CW;
  localparam int FB   = 2 * QUAT_FRAC_BITS;
  // room for the signed unit bound of the sine clamp
  localparam int PW   = (FB + 2 > q2e_pkg::PW) ? FB + 2 : q2e_pkg::PW;
  localparam int NST  = (CORDIC_STEPS < q2e_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                            : q2e_pkg::TABLE_LEN;

  logic signed [15:0] decl_r;
  logic               en;

  // pipeline advances unless the output register is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= q2e_pkg::DECL_RESET;
    end else if (cfg_we) begin
      decl_r <= cfg_wdata;
    end
  end

  // stage 1: products
  logic              v1_r;
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, wx_r, yz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
    if (en) begin
      ww_r <= in_quat_w * in_quat_w;  xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;  zz_r <= in_quat_z * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;  wz_r <= in_quat_w * in_quat_z;
      xz_r <= in_quat_x * in_quat_z;  wy_r <= in_quat_w * in_quat_y;
      wx_r <= in_quat_w * in_quat_x;  yz_r <= in_quat_y * in_quat_z;
    end
  end

  // stage 2: matrix terms and sine clamp
  logic v2_r, cl2_r;
  logic signed [PW-1:0] yn_r, yd_r, rn_r, rd_r, pa_r;
  logic signed [PW-1:0] pa_raw, unit;
  always_comb begin
    unit   = PW'(1) <<< FB;
    pa_raw = (PW'(xz_r) - PW'(wy_r)) <<< 1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      yn_r <= (PW'(xy_r) + PW'(wz_r)) <<< 1;
      yd_r <= PW'(ww_r) + PW'(xx_r) - PW'(yy_r) - PW'(zz_r);
      rn_r <= (PW'(wx_r) + PW'(yz_r)) <<< 1;
      rd_r <= PW'(ww_r) - PW'(xx_r) - PW'(yy_r) + PW'(zz_r);
      cl2_r <= (pa_raw > unit) || (pa_raw < -unit);
      pa_r  <= (pa_raw > unit) ? unit : ((pa_raw < -unit) ? -unit : pa_raw);
    end
  end

  // stage 3: sine to q30 and square
  logic v3_r, cl3_r;
  logic signed [CW-1:0] s30_r, s30_nxt;
  if (FB >= 30) begin : g_s30
    logic [PW-1:0] pmag;
    always_comb begin
      pmag    = pa_r[PW-1] ? PW'(-pa_r) : PW'(pa_r);
      s30_nxt = pa_r[PW-1] ? -CW'(pmag >> (FB - 30)) : CW'(pmag >> (FB - 30));
    end
  end else begin : g_s30
    always_comb begin
      s30_nxt = CW'(pa_r) <<< (30 - FB);
    end
  end
  logic [q2e_pkg::SQW-1:0] rad_r;
  logic [q2e_pkg::SQW-1:0] smag3;
  logic [2*q2e_pkg::SQW-1:0] sq3;
  always_comb begin
    smag3 = s30_r[CW-1] ? q2e_pkg::SQW'(-s30_r) : q2e_pkg::SQW'(s30_r);
    sq3   = smag3[30:0] * smag3[30:0];
  end
  logic v4_r, cl4_r;
  logic signed [CW-1:0] s4_r;
  logic signed [PW-1:0] yn3_r, yd3_r, rn3_r, rd3_r, yn4_r, yd4_r, rn4_r, rd4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    if (en) begin
      s30_r <= s30_nxt;  cl3_r <= cl2_r;
      yn3_r <= yn_r; yd3_r <= yd_r; rn3_r <= rn_r; rd3_r <= rd_r;
      // |s| <= 2^30 so s*s fits; 1 - s^2 in q60 stays below 2^61
      rad_r <= (q2e_pkg::SQW'(1) << 60) - sq3[q2e_pkg::SQW-1:0];
      s4_r  <= s30_r; cl4_r <= cl3_r;
      yn4_r <= yn3_r; yd4_r <= yd3_r; rn4_r <= rn3_r; rd4_r <= rd3_r;
    end
  end

  // square root, with delay line carrying the two atan2 operand pairs
  logic v5, cl5;
  logic [q2e_pkg::RTW-1:0] root5;
  logic signed [CW-1:0] s5;
  q2e_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v4_r), .rad_in(rad_r),
    .s_in(s4_r), .clamp_in(cl4_r), .vld_out(v5), .root_out(root5),
    .s_out(s5), .clamp_out(cl5)
  );
  logic signed [PW-1:0] dly_yn [q2e_pkg::RTW+1];
  logic signed [PW-1:0] dly_yd [q2e_pkg::RTW+1];
  logic signed [PW-1:0] dly_rn [q2e_pkg::RTW+1];
  logic signed [PW-1:0] dly_rd [q2e_pkg::RTW+1];
  always_comb begin
    dly_yn[0] = yn4_r; dly_yd[0] = yd4_r; dly_rn[0] = rn4_r; dly_rd[0] = rd4_r;
  end
  for (genvar k = 0; k < q2e_pkg::RTW; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dly_yn[k+1] <= dly_yn[k]; dly_yd[k+1] <= dly_yd[k];
        dly_rn[k+1] <= dly_rn[k]; dly_rd[k+1] <= dly_rd[k];
      end
    end
  end

  // cordic prep stage: quadrant and normalize for three lanes
  logic v6_r, cl6_r;
  q2e_pkg::cvec_t lane_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5;
    if (en) begin
      cl6_r     <= cl5;
      lane_r[0] <= q2e_pkg::cordic_prep(CW'(dly_yn[q2e_pkg::RTW]),
                                        CW'(dly_yd[q2e_pkg::RTW]));
      lane_r[1] <= q2e_pkg::cordic_prep(s5, CW'(root5));
      lane_r[2] <= q2e_pkg::cordic_prep(CW'(dly_rn[q2e_pkg::RTW]),
                                        CW'(dly_rd[q2e_pkg::RTW]));
    end
  end

  // cordic lanes
  q2e_pkg::cvec_t cv [3][NST+1];
  logic           cvv [3][NST+1];
  logic           clp [NST+1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cv[l][0]  = lane_r[l];
      cvv[l][0] = v6_r;
    end
    clp[0] = cl6_r;
  end
  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar s = 0; s < NST; s++) begin : g_step
      q2e_cordic_stage #(.STEP(s)) u_stage (
        .clk(clk), .rst_n(rst_n), .en(en),
        .vld_in(cvv[l][s]), .vec_in(cv[l][s]),
        .vld_out(cvv[l][s+1]), .vec_out(cv[l][s+1])
      );
    end
  end
  for (genvar s = 0; s < NST; s++) begin : g_clp
    always_ff @(posedge clk) begin
      if (en) clp[s+1] <= clp[s];
    end
  end

  // final stage: scale, subtract declination, saturate
  logic signed [17:0] yaw_h, pit_h, rol_h;
  always_comb begin
    yaw_h = cv[0][NST].zero ? 18'sd0 : q2e_pkg::to_hund(cv[0][NST].acc);
    pit_h = cv[1][NST].zero ? 18'sd0 : q2e_pkg::to_hund(cv[1][NST].acc);
    rol_h = cv[2][NST].zero ? 18'sd0 : q2e_pkg::to_hund(cv[2][NST].acc);
    yaw_h = q2e_pkg::sat(yaw_h - 18'(decl_r), 18'sd36000);
    pit_h = q2e_pkg::sat(-pit_h, 18'sd9000);
    rol_h = q2e_pkg::sat(rol_h, 18'sd18000);
  end
  logic vo_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= cvv[0][NST];
    if (en) begin
      out_yaw_angle     <= yaw_h[16:0];
      out_pitch_angle   <= pit_h[14:0];
      out_roll_angle    <= rol_h[15:0];
      out_pitch_clamped <= clp[NST];
    end
  end
  assign out_valid = vo_r;

  logic unused_lane_v;
  assign unused_lane_v = cvv[1][NST] ^ cvv[2][NST];
endmodule

// ----- rtl/q2e_checker.sv -----
// port-level checks for the quaternion to euler converter, bound to the top
module q2e_port_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] out_yaw_angle,
  input logic signed [14:0] out_pitch_angle,
  input logic signed [15:0] out_roll_angle
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_yaw_angle))
    else $error("result dropped or changed during stall");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= 15'sd9000 && out_pitch_angle >= -15'sd9000)
    else $error("pitch out of range");
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle <= 16'sd18000 && out_roll_angle >= -16'sd18000)
    else $error("roll out of range");
endmodule

bind quaternion_to_euler_angles_top q2e_port_props u_q2e_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_yaw_angle(out_yaw_angle),
  .out_pitch_angle(out_pitch_angle), .out_roll_angle(out_roll_angle)
);
